FILE: rtl/tldn_pkg.sv
// tldn_pkg: shared types, constants and month-table helpers for the thai lunar
// date converter. Used by tldn_div and thai_lunar_date_from_day_number.
package tldn_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_SETUP,
    ST_WALK,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_T,
    PH_D,
    PH_E,
    PH_M
  } phase_t;

  // divider steps: estimate, back-multiply, fix-up
  typedef enum logic [1:0] {
    DS_IDLE,
    DS_EST,
    DS_BACK,
    DS_FIX
  } div_step_t;

  localparam int NUM_W = 41;
  localparam int DEN_W = 30;
  localparam int QUO_W = 21;
  localparam int RCP_W = 32;

  // wide numerators use num[40:9] against a 2**49 reciprocal, narrow ones
  // use num[31:0] against a 2**32 reciprocal
  localparam int SH_WIDE   = 40;
  localparam int SH_NARROW = 32;

  typedef struct packed {
    logic             start;
    logic             wide;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [RCP_W-1:0] rcp;
  } div_req_t;

  // t = floor((2e6*R - 465302351603) / 730517500)
  localparam logic [DEN_W-1:0] K_T_MUL = 30'd2000000;
  localparam logic [NUM_W-1:0] K_T_OFS = 41'd465302351603;
  localparam logic [DEN_W-1:0] K_T_DEN = 30'd730517500;
  localparam logic [RCP_W-1:0] K_T_RCP = 32'd770618;
  // d = floor((365258750*y + 1490489) / 1e6)
  localparam logic [DEN_W-1:0] K_D_MUL = 30'd365258750;
  localparam logic [NUM_W-1:0] K_D_OFS = 41'd1490489;
  localparam logic [DEN_W-1:0] K_D_DEN = 30'd1000000;
  localparam logic [RCP_W-1:0] K_D_RCP = 32'd562949953;
  // epact correction (11d + 650) / 692, then mod 30
  localparam logic [DEN_W-1:0] K_E_MUL = 30'd11;
  localparam logic [NUM_W-1:0] K_E_OFS = 41'd650;
  localparam logic [DEN_W-1:0] K_E_DEN = 30'd692;
  localparam logic [RCP_W-1:0] K_E_RCP = 32'd6206600;
  localparam logic [DEN_W-1:0] K_M_DEN = 30'd30;
  localparam logic [RCP_W-1:0] K_M_RCP = 32'd143165576;

  localparam logic [20:0] K_R_BASE = 21'd730485;
  localparam logic [19:0] K_B_OFS  = 20'd232741;

  // month length for table index k; leap table differs from k=10 on
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] k,
                                           input logic extra);
    logic [4:0] len;
    if (k == 4'd8) begin
      len = extra ? 5'd30 : 5'd29;
    end else if (leap && k >= 4'd10) begin
      len = (k == 4'd10 || k == 4'd12) ? 5'd30 : 5'd29;
    end else begin
      len = k[0] ? 5'd30 : 5'd29;
    end
    return len;
  endfunction

  // forward walk in a leap year: step i maps to a calendar month
  function automatic logic [3:0] leap_month(input logic [3:0] i);
    logic [4:0] m;
    m = {1'b0, i} + 5'd6;
    if (m > 5'd9) begin
      m = m - 5'd1;
    end
    if (m > 5'd12) begin
      m = m - 5'd12;
    end
    return m[3:0];
  endfunction

endpackage

FILE: rtl/thai_lunar_date_from_day_number.sv
// thai_lunar_date_from_day_number: top level of the thai lunar date converter.
// Depends on tldn_pkg and tldn_div.
//
// Usage: one day offset comes in on the in_valid/in_ready channel and one
// lunar date (year, month, day, repeated-month flag) leaves on the
// out_valid/out_ready channel. The block handles one transaction at a time:
// in_ready is high only while idle. Work per item is seven constant divisions
// on the shared divider (era year, then year start, epact correction and
// mod 30 for year t and t+1). Each passes through a multiply state, a load
// state, the divider and a store state; a setup state and the month walk
// follow. The length of the month walk and the divider fix-up step make the
// time per item vary. Reset returns the sequencer to idle with no result
// pending. While the receiver stalls the result stays registered on the
// outputs and no new input is taken until it is accepted.
module thai_lunar_date_from_day_number (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [18:0] day_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] lunar_year,
  output logic [3:0]  lunar_month,
  output logic [4:0]  lunar_day,
  output logic        repeated_month
);

  tldn_pkg::state_t state, state_next;
  tldn_pkg::phase_t phase;
  logic             hi;

  tldn_pkg::div_req_t             req;
  logic                           div_done;
  logic [tldn_pkg::QUO_W-1:0]     quo;
  logic [tldn_pkg::NUM_W-1:0]     rem;

  logic [19:0] r;
  logic [11:0] t;
  logic [19:0] d0, d1;
  logic [13:0] qe;
  logic [4:0]  s0, s1;
  logic [49:0] product;

  logic [tldn_pkg::DEN_W-1:0] mul_a;
  logic [19:0]                mul_b;
  logic [20:0]                r_sum;
  logic [19:0]                dsel;

  // walk registers
  logic signed [11:0] de;
  logic [3:0]         idx;
  logic               fwd, leap, extra, borrow;

  tldn_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );

  assign in_ready = (state == tldn_pkg::ST_IDLE);
  assign r_sum    = {{2{day_offset[18]}}, day_offset} + tldn_pkg::K_R_BASE;
  assign dsel     = hi ? d1 : d0;

  always_comb begin
    mul_a = tldn_pkg::K_E_MUL;
    mul_b = dsel;
    case (phase)
      tldn_pkg::PH_T: begin
        mul_a = tldn_pkg::K_T_MUL;
        mul_b = r;
      end
      tldn_pkg::PH_D: begin
        mul_a = tldn_pkg::K_D_MUL;
        mul_b = {8'b0, t + {11'b0, hi}};
      end
      default: begin
        mul_a = tldn_pkg::K_E_MUL;
        mul_b = dsel;
      end
    endcase
  end

  always_comb begin
    req.start = (state == tldn_pkg::ST_LOAD);
    req.wide  = 1'b0;
    req.num   = '0;
    req.den   = tldn_pkg::K_M_DEN;
    req.rcp   = tldn_pkg::K_M_RCP;
    unique case (phase)
      tldn_pkg::PH_T: begin
        req.wide = 1'b1;
        req.num  = product[40:0] - tldn_pkg::K_T_OFS;
        req.den  = tldn_pkg::K_T_DEN;
        req.rcp  = tldn_pkg::K_T_RCP;
      end
      tldn_pkg::PH_D: begin
        req.wide = 1'b1;
        req.num  = product[40:0] + tldn_pkg::K_D_OFS;
        req.den  = tldn_pkg::K_D_DEN;
        req.rcp  = tldn_pkg::K_D_RCP;
      end
      tldn_pkg::PH_E: begin
        req.num = product[40:0] + tldn_pkg::K_E_OFS;
        req.den = tldn_pkg::K_E_DEN;
        req.rcp = tldn_pkg::K_E_RCP;
      end
      tldn_pkg::PH_M: begin
        req.num = {21'b0, dsel} + {27'b0, qe};
        req.den = tldn_pkg::K_M_DEN;
        req.rcp = tldn_pkg::K_M_RCP;
      end
      default: ;
    endcase
  end

  // walk step
  logic [3:0]         k;
  logic [4:0]         len;
  logic signed [11:0] diff, sum;
  logic               stop, last;
  logic [3:0]         wmonth;

  always_comb begin
    if (!fwd) begin
      k = (idx <= 4'd6) ? idx + 4'd6 : idx - 4'd6;
    end else if (leap) begin
      k = (idx >= 4'd7) ? idx - 4'd7 : idx + 4'd6;
    end else begin
      k = (idx >= 4'd6) ? idx - 4'd6 : idx + 4'd6;
    end
    len  = tldn_pkg::month_len(fwd & leap, k, extra);
    diff = de - {7'b0, len};
    sum  = de + {7'b0, len};
    stop = fwd ? diff[11] : !sum[11];
    if (fwd) begin
      last = leap ? (idx == 4'd13) : (idx == 4'd12);
    end else begin
      last = (idx == 4'd1);
    end
    if (fwd && leap) begin
      wmonth = tldn_pkg::leap_month(idx);
    end else begin
      wmonth = (k == 4'd0) ? 4'd12 : k;
    end
  end

  // year setup values
  logic [5:0]         s0a, s1a;
  logic signed [21:0] span, de_full;
  logic signed [5:0]  shift;
  logic [19:0]        base;

  always_comb begin
    s0a     = (s0 < 5'd8) ? {1'b0, s0} + 6'd30 : {1'b0, s0};
    s1a     = (s1 < 5'd8) ? {1'b0, s1} + 6'd30 : {1'b0, s1};
    span    = $signed({2'b0, d1}) - $signed({2'b0, d0})
            + $signed({17'b0, s0}) - $signed({16'b0, s1a});
    shift   = (s0 >= 5'd8) ? $signed({1'b0, s0}) - 6'sd30 : $signed({1'b0, s0});
    base    = r - tldn_pkg::K_B_OFS;
    de_full = $signed({2'b0, base}) - $signed({2'b0, d0}) + 22'(shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tldn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tldn_pkg::ST_IDLE:  if (in_valid) state_next = tldn_pkg::ST_MUL;
      tldn_pkg::ST_MUL:   state_next = tldn_pkg::ST_LOAD;
      tldn_pkg::ST_LOAD:  state_next = tldn_pkg::ST_DIV;
      tldn_pkg::ST_DIV:   if (div_done) state_next = tldn_pkg::ST_STORE;
      tldn_pkg::ST_STORE: begin
        if (phase == tldn_pkg::PH_M && hi) state_next = tldn_pkg::ST_SETUP;
        else state_next = tldn_pkg::ST_MUL;
      end
      tldn_pkg::ST_SETUP: state_next = tldn_pkg::ST_WALK;
      tldn_pkg::ST_WALK:  if (stop || last) state_next = tldn_pkg::ST_OUT;
      tldn_pkg::ST_OUT:   if (out_ready) state_next = tldn_pkg::ST_IDLE;
      default:            state_next = tldn_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = (state == tldn_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    unique case (state)
      tldn_pkg::ST_IDLE: begin
        r     <= r_sum[19:0];
        phase <= tldn_pkg::PH_T;
        hi    <= 1'b0;
      end
      tldn_pkg::ST_MUL: begin
        product <= {20'b0, mul_a} * {30'b0, mul_b};
      end
      tldn_pkg::ST_STORE: begin
        unique case (phase)
          tldn_pkg::PH_T: begin
            t     <= quo[11:0];
            phase <= tldn_pkg::PH_D;
          end
          tldn_pkg::PH_D: begin
            if (hi) d1 <= quo[19:0];
            else d0 <= quo[19:0];
            phase <= tldn_pkg::PH_E;
          end
          tldn_pkg::PH_E: begin
            qe    <= quo[13:0];
            phase <= tldn_pkg::PH_M;
          end
          tldn_pkg::PH_M: begin
            if (hi) s1 <= rem[4:0];
            else s0 <= rem[4:0];
            phase <= tldn_pkg::PH_D;
            hi    <= 1'b1;
          end
          default: ;
        endcase
      end
      tldn_pkg::ST_SETUP: begin
        leap   <= s1a < s0a;
        extra  <= (s1a < s0a) ? (span >= 22'sd385) : (span >= 22'sd355);
        de     <= de_full[11:0];
        fwd    <= !de_full[21];
        idx    <= de_full[21] ? 4'd12 : 4'd1;
        borrow <= base < d0;
      end
      tldn_pkg::ST_WALK: begin
        lunar_year     <= t - {11'b0, borrow};
        repeated_month <= stop && fwd && leap && (idx == 4'd4);
        if (stop) begin
          lunar_month <= wmonth;
          lunar_day   <= fwd ? 5'(de + 12'sd1) : 5'(sum + 12'sd1);
        end else if (last) begin
          // table exhausted: month reads zero
          lunar_month <= 4'd0;
          lunar_day   <= fwd ? 5'(diff + 12'sd1) : 5'(sum + 12'sd30);
        end else begin
          de  <= fwd ? diff : sum;
          idx <= fwd ? idx + 4'd1 : idx - 4'd1;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lunar_month >= 4'd1 && lunar_month <= 4'd12))
    else $error("month walk ran off the table");

  a_day_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lunar_day != 5'd0))
    else $error("day of month is zero");

  a_repeat_month: assert property (@(posedge clk) disable iff (rst)
    (out_valid && repeated_month) |-> (lunar_month == 4'd9))
    else $error("repeated month flag outside month nine");

endmodule

FILE: rtl/tldn_div.sv
// tldn_div: constant divider by reciprocal multiply, back-multiply and fix-up.
// Takes a tldn_pkg::div_req_t; quotients must stay below 2**QUO_W.
module tldn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  tldn_pkg::div_req_t        req,
  output logic                      done,
  output logic [tldn_pkg::QUO_W-1:0] quo,
  output logic [tldn_pkg::NUM_W-1:0] rem
);

  localparam int PROD_W = 2 * tldn_pkg::RCP_W;
  localparam int REM_W  = tldn_pkg::NUM_W + 1;
  localparam logic [tldn_pkg::QUO_W-1:0] QUO_ONE = 1;

  tldn_pkg::div_step_t step, step_next;

  logic [tldn_pkg::NUM_W-1:0] num;
  logic [tldn_pkg::DEN_W-1:0] den;
  logic [tldn_pkg::RCP_W-1:0] rcp;
  logic                       wide;
  logic signed [REM_W-1:0]    rem_s;
  logic signed [REM_W-1:0]    den_s;
  logic [tldn_pkg::RCP_W-1:0] mul_x, mul_y;
  logic [PROD_W-1:0]          prod;
  logic [tldn_pkg::QUO_W-1:0] est;
  logic                       neg, over;

  assign den_s = {{(REM_W - tldn_pkg::DEN_W){1'b0}}, den};
  assign neg   = rem_s[REM_W-1];
  assign over  = (rem_s >= den_s);
  assign rem   = rem_s[tldn_pkg::NUM_W-1:0];

  // one multiplier: numerator times reciprocal, then quotient times divisor
  always_comb begin
    if (step == tldn_pkg::DS_EST) begin
      mul_x = wide ? num[tldn_pkg::NUM_W-1:tldn_pkg::NUM_W-tldn_pkg::RCP_W]
                   : num[tldn_pkg::RCP_W-1:0];
      mul_y = rcp;
    end else begin
      mul_x = {{(tldn_pkg::RCP_W - tldn_pkg::QUO_W){1'b0}}, quo};
      mul_y = {{(tldn_pkg::RCP_W - tldn_pkg::DEN_W){1'b0}}, den};
    end
    prod = {{tldn_pkg::RCP_W{1'b0}}, mul_x} * {{tldn_pkg::RCP_W{1'b0}}, mul_y};
    est  = wide ? prod[tldn_pkg::SH_WIDE+tldn_pkg::QUO_W-1:tldn_pkg::SH_WIDE]
                : prod[tldn_pkg::SH_NARROW+tldn_pkg::QUO_W-1:tldn_pkg::SH_NARROW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tldn_pkg::DS_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (step == tldn_pkg::DS_FIX) && !neg && !over;
    end
  end

  always_comb begin
    step_next = step;
    unique case (step)
      tldn_pkg::DS_IDLE: if (req.start) step_next = tldn_pkg::DS_EST;
      tldn_pkg::DS_EST:  step_next = tldn_pkg::DS_BACK;
      tldn_pkg::DS_BACK: step_next = tldn_pkg::DS_FIX;
      tldn_pkg::DS_FIX:  if (!neg && !over) step_next = tldn_pkg::DS_IDLE;
      default:           step_next = tldn_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (step)
      tldn_pkg::DS_IDLE: begin
        if (req.start) begin
          num  <= req.num;
          den  <= req.den;
          rcp  <= req.rcp;
          wide <= req.wide;
        end
      end
      tldn_pkg::DS_EST: begin
        quo <= est;
      end
      tldn_pkg::DS_BACK: begin
        rem_s <= $signed({1'b0, num}) - $signed(prod[REM_W-1:0]);
      end
      tldn_pkg::DS_FIX: begin
        // estimate is off by at most one
        if (neg) begin
          rem_s <= rem_s + den_s;
          quo   <= quo - QUO_ONE;
        end else if (over) begin
          rem_s <= rem_s - den_s;
          quo   <= quo + QUO_ONE;
        end
      end
      default: ;
    endcase
  end

endmodule
